/* rtl/core/dns_esr_pkg.sv */
package dns_esr_pkg;

   // one input item: a message byte and its end marker
   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_in;
   } req_type;

   // one result item
   typedef struct packed {
      logic [7:0] byte_out;
      logic       last_out;
      logic       rewritten;
   } rsp_type;

   // message section being parsed
   typedef enum logic [4:0] {
      PH_HEADER     = 5'b00001,
      PH_QUESTION   = 5'b00010,
      PH_RECORD     = 5'b00100,
      PH_ADDITIONAL = 5'b01000,
      PH_DONE       = 5'b10000
   } phase_type;

   // position inside a name or the fixed fields after it
   typedef enum logic [3:0] {
      NM_LEN   = 4'b0001,
      NM_LABEL = 4'b0010,
      NM_PTR   = 4'b0100,
      NM_FIXED = 4'b1000
   } name_mode_type;

   // header byte offsets of the section counts
   localparam logic [3:0] HDR_QD_HI   = 4'd4;
   localparam logic [3:0] HDR_QD_LO   = 4'd5;
   localparam logic [3:0] HDR_AN_HI   = 4'd6;
   localparam logic [3:0] HDR_AN_LO   = 4'd7;
   localparam logic [3:0] HDR_NS_HI   = 4'd8;
   localparam logic [3:0] HDR_NS_LO   = 4'd9;
   localparam logic [3:0] HDR_AR_HI   = 4'd10;
   localparam logic [3:0] HDR_AR_LO   = 4'd11;
   localparam logic [3:0] HEADER_LAST = 4'd11;

   // record fixed field offsets after the name
   localparam logic [3:0] FLD_TYPE_HI  = 4'd0;
   localparam logic [3:0] FLD_TYPE_LO  = 4'd1;
   localparam logic [3:0] FLD_CLASS_HI = 4'd2;
   localparam logic [3:0] FLD_CLASS_LO = 4'd3;
   localparam logic [3:0] FLD_RDLEN_HI = 4'd8;
   localparam logic [3:0] FLD_RDLEN_LO = 4'd9;
   localparam logic [3:0] RDATA_POS    = 4'd10;
   localparam logic [3:0] QFIXED_LAST  = 4'd3;

   // label length byte tags
   localparam logic [1:0] TAG_LABEL   = 2'b00;
   localparam logic [1:0] TAG_POINTER = 2'b11;

   localparam logic [15:0] OPT_TYPE           = 16'd41;
   localparam logic [15:0] PAYLOAD_SIZE_RESET = 16'd512;

endpackage

/* rtl/core/dns_edns_size_rewriter.sv */
// a result item is registered and appears in the cycle after its input item is accepted
// throughput: one item per cycle, set by the single parse-state register update
//    done for each byte; a waiting result stalls the input only while the receiver stalls
// reset (synchronous, active high): parse state returns to the header phase,
//    payload_size returns to 512, and no result is pending
module dns_edns_size_rewriter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dns_esr_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dns_esr_pkg::rsp_type rsp_data,
   input  logic                 csr_write_enable,
   input  logic [15:0]          csr_write_data
);

   logic [15:0] payload_size_ff;

   dns_esr_pkg::phase_type     phase_ff, phase_in;
   logic [3:0]                 header_pos_ff, header_pos_in;
   logic [15:0]                questions_ff, questions_in;
   logic [16:0]                records_ff, records_in;
   logic [15:0]                additional_ff, additional_in;
   dns_esr_pkg::name_mode_type name_mode_ff, name_mode_in;
   logic [5:0]                 label_left_ff, label_left_in;
   logic [3:0]                 field_pos_ff, field_pos_in;
   logic [15:0]                rdata_left_ff, rdata_left_in;
   logic                       root_name_ff, root_name_in;
   logic [15:0]                record_type_ff, record_type_in;
   logic                       opt_done_ff, opt_done_in;

   logic                 rsp_valid_ff;
   dns_esr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic        item_end;
   logic        item_next;
   logic [5:0]  label_dec;
   logic [15:0] rdata_dec;
   logic [15:0] rdata_len;
   logic [7:0]  b;

   // output register parts the two sides
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign b         = req_data.byte_in;
   assign label_dec = label_left_ff - 6'd1;
   assign rdata_dec = rdata_left_ff - 16'd1;
   assign rdata_len = {rdata_left_ff[15:8], b};

   // parse step for one byte
   always_comb begin
      phase_in       = phase_ff;
      header_pos_in  = header_pos_ff;
      questions_in   = questions_ff;
      records_in     = records_ff;
      additional_in  = additional_ff;
      name_mode_in   = name_mode_ff;
      label_left_in  = label_left_ff;
      field_pos_in   = field_pos_ff;
      rdata_left_in  = rdata_left_ff;
      root_name_in   = root_name_ff;
      record_type_in = record_type_ff;
      opt_done_in    = opt_done_ff;
      item_end       = 1'b0;
      item_next      = 1'b0;
      rsp_data_in.byte_out  = b;
      rsp_data_in.last_out  = req_data.last_in;
      rsp_data_in.rewritten = 1'b0;

      case (phase_ff)
         dns_esr_pkg::PH_HEADER: begin
            case (header_pos_ff)
               dns_esr_pkg::HDR_QD_HI: questions_in = {b, 8'h00};
               dns_esr_pkg::HDR_QD_LO: questions_in = {questions_ff[15:8], b};
               dns_esr_pkg::HDR_AN_HI: records_in = {1'b0, b, 8'h00};
               dns_esr_pkg::HDR_AN_LO: records_in = {records_ff[16:8], b};
               dns_esr_pkg::HDR_NS_HI: records_in = records_ff + {1'b0, b, 8'h00};
               dns_esr_pkg::HDR_NS_LO: records_in = records_ff + {9'h000, b};
               dns_esr_pkg::HDR_AR_HI: additional_in = {b, 8'h00};
               dns_esr_pkg::HDR_AR_LO: additional_in = {additional_ff[15:8], b};
               default: ;
            endcase
            header_pos_in = header_pos_ff + 4'd1;
            if (header_pos_ff == dns_esr_pkg::HEADER_LAST) begin
               item_next = 1'b1;
            end
         end
         dns_esr_pkg::PH_QUESTION, dns_esr_pkg::PH_RECORD,
         dns_esr_pkg::PH_ADDITIONAL: begin
            case (name_mode_ff)
               dns_esr_pkg::NM_LEN: begin
                  if (b == 8'h00) begin
                     name_mode_in = dns_esr_pkg::NM_FIXED;
                     field_pos_in = 4'd0;
                  end else if (b[7:6] == dns_esr_pkg::TAG_POINTER) begin
                     root_name_in = 1'b0;
                     name_mode_in = dns_esr_pkg::NM_PTR;
                  end else if (b[7:6] != dns_esr_pkg::TAG_LABEL) begin
                     // reserved label type stops parsing
                     phase_in = dns_esr_pkg::PH_DONE;
                  end else begin
                     root_name_in  = 1'b0;
                     label_left_in = b[5:0];
                     name_mode_in  = dns_esr_pkg::NM_LABEL;
                  end
               end
               dns_esr_pkg::NM_LABEL: begin
                  label_left_in = label_dec;
                  if (label_dec == 6'd0) begin
                     name_mode_in = dns_esr_pkg::NM_LEN;
                  end
               end
               dns_esr_pkg::NM_PTR: begin
                  name_mode_in = dns_esr_pkg::NM_FIXED;
                  field_pos_in = 4'd0;
               end
               dns_esr_pkg::NM_FIXED: begin
                  if (phase_ff == dns_esr_pkg::PH_QUESTION) begin
                     // question type and class
                     if (field_pos_ff >= dns_esr_pkg::QFIXED_LAST) begin
                        item_end = 1'b1;
                     end else begin
                        field_pos_in = field_pos_ff + 4'd1;
                     end
                  end else if (field_pos_ff >= dns_esr_pkg::RDATA_POS) begin
                     // skip rdata
                     rdata_left_in = rdata_dec;
                     if (rdata_dec == 16'd0) begin
                        item_end = 1'b1;
                     end
                  end else begin
                     case (field_pos_ff)
                        dns_esr_pkg::FLD_TYPE_HI: record_type_in = {b, 8'h00};
                        dns_esr_pkg::FLD_TYPE_LO: record_type_in = {record_type_ff[15:8], b};
                        dns_esr_pkg::FLD_CLASS_HI, dns_esr_pkg::FLD_CLASS_LO: begin
                           // class of the first root-name opt record
                           if (phase_ff == dns_esr_pkg::PH_ADDITIONAL && root_name_ff &&
                               record_type_ff == dns_esr_pkg::OPT_TYPE && !opt_done_ff) begin
                              rsp_data_in.rewritten = 1'b1;
                              if (field_pos_ff == dns_esr_pkg::FLD_CLASS_HI) begin
                                 rsp_data_in.byte_out = payload_size_ff[15:8];
                              end else begin
                                 rsp_data_in.byte_out = payload_size_ff[7:0];
                                 opt_done_in          = 1'b1;
                              end
                           end
                        end
                        dns_esr_pkg::FLD_RDLEN_HI: rdata_left_in = {b, 8'h00};
                        dns_esr_pkg::FLD_RDLEN_LO: rdata_left_in = rdata_len;
                        default: ;
                     endcase
                     if (field_pos_ff == dns_esr_pkg::FLD_RDLEN_LO) begin
                        if (rdata_len == 16'd0) begin
                           item_end = 1'b1;
                        end else begin
                           field_pos_in = dns_esr_pkg::RDATA_POS;
                        end
                     end else begin
                        field_pos_in = field_pos_ff + 4'd1;
                     end
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      // count down the section of the finished entry
      if (item_end) begin
         case (phase_ff)
            dns_esr_pkg::PH_QUESTION: questions_in = questions_ff - 16'd1;
            dns_esr_pkg::PH_RECORD:   records_in = records_ff - 17'd1;
            default:                  additional_in = additional_ff - 16'd1;
         endcase
         item_next = 1'b1;
      end

      // pick the next section with entries left
      if (item_next) begin
         if (questions_in != 16'd0) begin
            phase_in = dns_esr_pkg::PH_QUESTION;
         end else if (records_in != 17'd0) begin
            phase_in = dns_esr_pkg::PH_RECORD;
         end else if (additional_in != 16'd0) begin
            phase_in = dns_esr_pkg::PH_ADDITIONAL;
         end else begin
            phase_in = dns_esr_pkg::PH_DONE;
         end
         if (phase_in != dns_esr_pkg::PH_DONE) begin
            name_mode_in   = dns_esr_pkg::NM_LEN;
            label_left_in  = 6'd0;
            field_pos_in   = 4'd0;
            rdata_left_in  = 16'd0;
            root_name_in   = 1'b1;
            record_type_in = 16'd0;
         end
      end

      // end of message clears the parse state
      if (req_data.last_in) begin
         phase_in       = dns_esr_pkg::PH_HEADER;
         header_pos_in  = 4'd0;
         questions_in   = 16'd0;
         records_in     = 17'd0;
         additional_in  = 16'd0;
         name_mode_in   = dns_esr_pkg::NM_LEN;
         label_left_in  = 6'd0;
         field_pos_in   = 4'd0;
         rdata_left_in  = 16'd0;
         root_name_in   = 1'b0;
         record_type_in = 16'd0;
         opt_done_in    = 1'b0;
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= dns_esr_pkg::PH_HEADER;
         header_pos_ff  <= 4'd0;
         questions_ff   <= 16'd0;
         records_ff     <= 17'd0;
         additional_ff  <= 16'd0;
         name_mode_ff   <= dns_esr_pkg::NM_LEN;
         label_left_ff  <= 6'd0;
         field_pos_ff   <= 4'd0;
         rdata_left_ff  <= 16'd0;
         root_name_ff   <= 1'b0;
         record_type_ff <= 16'd0;
         opt_done_ff    <= 1'b0;
      end else if (req_fire) begin
         phase_ff       <= phase_in;
         header_pos_ff  <= header_pos_in;
         questions_ff   <= questions_in;
         records_ff     <= records_in;
         additional_ff  <= additional_in;
         name_mode_ff   <= name_mode_in;
         label_left_ff  <= label_left_in;
         field_pos_ff   <= field_pos_in;
         rdata_left_ff  <= rdata_left_in;
         root_name_ff   <= root_name_in;
         record_type_ff <= record_type_in;
         opt_done_ff    <= opt_done_in;
      end
   end

   // payload size register
   always_ff @(posedge clock) begin
      if (reset) begin
         payload_size_ff <= dns_esr_pkg::PAYLOAD_SIZE_RESET;
      end else if (csr_write_enable) begin
         payload_size_ff <= csr_write_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_fire || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a new item is only held back by a result that is waiting
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with no result pending");

   // a rewritten byte carries one of the payload size bytes
   a_rewrite_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.rewritten) |->
         (rsp_data_ff.byte_out == payload_size_ff[15:8] ||
          rsp_data_ff.byte_out == payload_size_ff[7:0]))
      else $error("rewritten byte does not match payload size");

   // the second class byte marks the opt record done
   a_opt_done_set: assert property (@(posedge clock) disable iff (reset)
      (req_fire && rsp_data_in.rewritten && !req_data.last_in &&
       field_pos_ff == dns_esr_pkg::FLD_CLASS_LO) |=> opt_done_ff)
      else $error("opt record not marked done after rewrite");

   // after the final byte the parser is back at the header
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.last_in) |=>
         (phase_ff == dns_esr_pkg::PH_HEADER && header_pos_ff == 4'd0 && !opt_done_ff))
      else $error("parse state not cleared at end of message");

endmodule
